>>> rtl/bbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared sizes, codes and types of the binary boundary extractor.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int MIN_SIZE    = 3;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_COORD_W = 11;

    // results caused by one pixel at most
    localparam int MAX_RES     = 4;
    localparam int FIFO_DEPTH  = 16;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int STALL_LEVEL = FIFO_DEPTH - MAX_RES;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef logic [COL_W-1:0]       col_t;
    typedef logic [ROW_W-1:0]       row_t;
    typedef logic [CFG_W-1:0]       cfg_t;
    typedef logic [OUT_COORD_W-1:0] coord_t;
    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [PTR_W:0]         cnt_t;

    // line store entry: [1] two rows up, [0] one row up
    typedef logic [1:0] line_t;

    typedef struct packed {
        logic   edge_set;
        coord_t row;
        coord_t col;
        logic   frame_done;
    } result_t;

    // pixel waiting for its line store read
    typedef struct packed {
        logic valid;
        row_t r;
        col_t c;
        logic cur;
        logic last_col;
        logic last_row;
    } stage_t;

    // up to four results pushed in one cycle, in emission order
    typedef struct packed {
        logic [MAX_RES-1:0] en;
        result_t [MAX_RES-1:0] res;
    } push_t;

endpackage

>>> rtl/bbe_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_line_store
// Two line stores packed side by side in one synchronous RAM, one entry per
// column, registered read data.
// ----------------------------------------------------------------------------
module bbe_line_store (
    input  logic                 clk,
    input  logic                 rd_en,
    input  bbe_pkg::col_t        rd_addr,
    output bbe_pkg::line_t       rd_data,
    input  logic                 wr_en,
    input  bbe_pkg::col_t        wr_addr,
    input  bbe_pkg::line_t       wr_data
);

    bbe_pkg::line_t mem [bbe_pkg::MAX_WIDTH];
    bbe_pkg::line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bbe_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_kernel
// 3x2 window register and the boundary decision for the pixel one row up and
// one column back, plus the last-row and last-column results.
// ----------------------------------------------------------------------------
module bbe_kernel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbe_pkg::stage_t      stage,
    input  bbe_pkg::line_t       line,
    input  bbe_pkg::col_t        last_col_idx,
    input  bbe_pkg::row_t        last_row_idx,
    output bbe_pkg::push_t       push
);

    logic [5:0] window_reg;
    logic [5:0] window_next;
    logic       a;
    logic       b;
    logic       up;
    logic       ctr;
    logic       dn;
    logic       left;
    logic       r_nz;
    logic       c_nz;
    logic       e;

    assign a    = line[1];
    assign b    = line[0];
    assign up   = window_reg[0];
    assign ctr  = window_reg[1];
    assign dn   = window_reg[2];
    assign left = window_reg[4];

    assign r_nz = (stage.r != '0);
    assign c_nz = (stage.c != '0);

    // next to the first row or column the centre pixel is a border copy
    assign e = ((stage.r == bbe_pkg::row_t'(1)) || (stage.c == bbe_pkg::col_t'(1))) ?
               ctr : (ctr & ~(up & left & b & dn));

    assign window_next = {window_reg[2:0], stage.cur, b, a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (stage.valid)
        begin
            window_reg <= window_next;
        end
    end

    always_comb
    begin
        push.en[0] = stage.valid & r_nz & c_nz;
        push.en[1] = stage.valid & r_nz & stage.last_col;
        push.en[2] = stage.valid & stage.last_row & c_nz;
        push.en[3] = stage.valid & stage.last_row & stage.last_col;

        push.res[0].edge_set   = e;
        push.res[0].row        = bbe_pkg::coord_t'(stage.r - 1'b1);
        push.res[0].col        = bbe_pkg::coord_t'(stage.c - 1'b1);
        push.res[0].frame_done = 1'b0;

        push.res[1].edge_set   = b;
        push.res[1].row        = bbe_pkg::coord_t'(stage.r - 1'b1);
        push.res[1].col        = bbe_pkg::coord_t'(last_col_idx);
        push.res[1].frame_done = 1'b0;

        push.res[2].edge_set   = dn;
        push.res[2].row        = bbe_pkg::coord_t'(last_row_idx);
        push.res[2].col        = bbe_pkg::coord_t'(stage.c - 1'b1);
        push.res[2].frame_done = 1'b0;

        push.res[3].edge_set   = stage.cur;
        push.res[3].row        = bbe_pkg::coord_t'(last_row_idx);
        push.res[3].col        = bbe_pkg::coord_t'(last_col_idx);
        push.res[3].frame_done = 1'b1;
    end

endmodule

>>> rtl/bbe_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_result_fifo
// Result queue: up to four packed writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module bbe_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbe_pkg::push_t       push,
    input  logic                 pop,
    output bbe_pkg::result_t     head,
    output bbe_pkg::cnt_t        count
);

    bbe_pkg::result_t mem_reg [bbe_pkg::FIFO_DEPTH];
    bbe_pkg::ptr_t    wr_ptr_reg;
    bbe_pkg::ptr_t    wr_ptr_next;
    bbe_pkg::ptr_t    rd_ptr_reg;
    bbe_pkg::ptr_t    rd_ptr_next;
    bbe_pkg::cnt_t    count_reg;
    bbe_pkg::cnt_t    count_next;
    bbe_pkg::ptr_t    slot [bbe_pkg::MAX_RES];
    bbe_pkg::ptr_t    n_push;

    // enabled results fill consecutive slots
    always_comb
    begin
        bbe_pkg::ptr_t off;
        off = '0;
        for (int k = 0; k < bbe_pkg::MAX_RES; k++)
        begin
            slot[k] = bbe_pkg::ptr_t'(wr_ptr_reg + off);
            off     = bbe_pkg::ptr_t'(off + bbe_pkg::ptr_t'(push.en[k]));
        end
        n_push = off;
    end

    always_comb
    begin
        wr_ptr_next = bbe_pkg::ptr_t'(wr_ptr_reg + n_push);
        rd_ptr_next = bbe_pkg::ptr_t'(rd_ptr_reg + bbe_pkg::ptr_t'(pop));
        count_next  = bbe_pkg::cnt_t'(count_reg + bbe_pkg::cnt_t'(n_push)
                                      - bbe_pkg::cnt_t'(pop));
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < bbe_pkg::MAX_RES; k++)
        begin
            if (push.en[k])
            begin
                mem_reg[slot[k]] <= push.res[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

>>> rtl/binary_boundary_extract_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_boundary_extract_top
// 4-connected inner boundary of a binary raster image, one pixel per clock unless pix_stall is high.
// ----------------------------------------------------------------------------
// Pixel channel: pixel_set with pix_valid / pix_stall, raster order, one
// pixel per transfer. Result channel: edge_set, out_row, out_col, frame_done
// with res_valid / res_stall. Config: cfg_valid / cfg_ready (always ready),
// cfg_index 0 = image width, 1 = image height; sizes saturate to 3..2048.
// Write config only while the block is idle.
// Each pixel goes through a line store read, then its results
// (none to four) are pushed into a 16-entry result queue. With the queue
// empty, a result shows on the result port once the stage register and
// the queue have registered it, and it transfers while res_stall is low.
// Throughput is one pixel per clock while the receiver keeps up. On the last
// row every pixel causes two results, so the single-read queue output halves
// the pixel rate there; the extra result at a row end is balanced by the
// first-column pixel, which causes none. pix_stall rises when the queue
// cannot hold the results of the pixel in flight plus four more; a stalled
// receiver holds the head result and fills the queue until pixels stall.
// Reset clears the counters, window and queue; the line store needs no
// clearing, its unwritten entries only feed border copies.
// ----------------------------------------------------------------------------
module binary_boundary_extract_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic                          pixel_set,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          edge_set,
    output logic [bbe_pkg::OUT_COORD_W-1:0] out_row,
    output logic [bbe_pkg::OUT_COORD_W-1:0] out_col,
    output logic                          frame_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbe_pkg::CFG_W-1:0]     cfg_data
);

    bbe_pkg::col_t    last_col_reg;
    bbe_pkg::col_t    last_col_next;
    bbe_pkg::row_t    last_row_reg;
    bbe_pkg::row_t    last_row_next;
    bbe_pkg::col_t    cfg_col_last;
    bbe_pkg::row_t    cfg_row_last;
    bbe_pkg::col_t    col_reg;
    bbe_pkg::col_t    col_next;
    bbe_pkg::row_t    row_reg;
    bbe_pkg::row_t    row_next;
    bbe_pkg::col_t    c_eff;
    bbe_pkg::row_t    r_eff;
    bbe_pkg::stage_t  stage_reg;
    bbe_pkg::stage_t  stage_next;
    bbe_pkg::line_t   line_rd;
    bbe_pkg::push_t   push;
    bbe_pkg::result_t head;
    bbe_pkg::cnt_t    fifo_count;
    bbe_pkg::cnt_t    fill;
    logic             pix_xfer;
    logic             res_xfer;

    // --- configuration ---
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (int'(cfg_data) < bbe_pkg::MIN_SIZE)
        begin
            cfg_col_last = bbe_pkg::col_t'(bbe_pkg::MIN_SIZE - 1);
            cfg_row_last = bbe_pkg::row_t'(bbe_pkg::MIN_SIZE - 1);
        end
        else
        begin
            cfg_col_last = (int'(cfg_data) > bbe_pkg::MAX_WIDTH) ?
                           bbe_pkg::col_t'(bbe_pkg::MAX_WIDTH - 1) :
                           bbe_pkg::col_t'(cfg_data - 1'b1);
            cfg_row_last = (int'(cfg_data) > bbe_pkg::MAX_HEIGHT) ?
                           bbe_pkg::row_t'(bbe_pkg::MAX_HEIGHT - 1) :
                           bbe_pkg::row_t'(cfg_data - 1'b1);
        end
    end

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bbe_pkg::REG_IMAGE_WIDTH:  last_col_next = cfg_col_last;
                bbe_pkg::REG_IMAGE_HEIGHT: last_row_next = cfg_row_last;
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    // --- raster position ---
    assign pix_xfer = pix_valid && !pix_stall;

    // a frame size shrunk between frames pulls the position back in
    assign c_eff = (col_reg > last_col_reg) ? last_col_reg : col_reg;
    assign r_eff = (row_reg > last_row_reg) ? last_row_reg : row_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_xfer)
        begin
            if (c_eff >= last_col_reg)
            begin
                col_next = '0;
                row_next = (r_eff >= last_row_reg) ? '0 :
                           bbe_pkg::row_t'(r_eff + 1'b1);
            end
            else
            begin
                col_next = bbe_pkg::col_t'(c_eff + 1'b1);
            end
        end
    end

    always_comb
    begin
        stage_next.valid    = pix_xfer;
        stage_next.r        = r_eff;
        stage_next.c        = c_eff;
        stage_next.cur      = pixel_set;
        stage_next.last_col = (c_eff == last_col_reg);
        stage_next.last_row = (r_eff == last_row_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= bbe_pkg::col_t'(640 - 1);
            last_row_reg <= bbe_pkg::row_t'(480 - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            stage_reg    <= '0;
        end
        else
        begin
            last_col_reg    <= last_col_next;
            last_row_reg    <= last_row_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            stage_reg.valid <= stage_next.valid;
            if (pix_xfer)
            begin
                stage_reg.r        <= stage_next.r;
                stage_reg.c        <= stage_next.c;
                stage_reg.cur      <= stage_next.cur;
                stage_reg.last_col <= stage_next.last_col;
                stage_reg.last_row <= stage_next.last_row;
            end
        end
    end

    // --- line stores: read on transfer, write back the shifted pair ---
    // consecutive pixels always hit different columns (width >= 3)
    bbe_line_store u_line_store (
        .clk     (clk),
        .rd_en   (pix_xfer),
        .rd_addr (c_eff),
        .rd_data (line_rd),
        .wr_en   (stage_reg.valid),
        .wr_addr (stage_reg.c),
        .wr_data ({line_rd[0], stage_reg.cur})
    );

    bbe_kernel u_kernel (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage_reg),
        .line         (line_rd),
        .last_col_idx (last_col_reg),
        .last_row_idx (last_row_reg),
        .push         (push)
    );

    // --- result queue ---
    assign res_xfer = res_valid && !res_stall;

    bbe_result_fifo u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (res_xfer),
        .head  (head),
        .count (fifo_count)
    );

    // room for the pixel in flight and one more
    assign fill = bbe_pkg::cnt_t'(fifo_count +
                  (stage_reg.valid ? bbe_pkg::cnt_t'(bbe_pkg::MAX_RES) : '0));
    assign pix_stall = (fill > bbe_pkg::cnt_t'(bbe_pkg::STALL_LEVEL));

    assign res_valid  = (fifo_count != '0);
    assign edge_set   = head.edge_set;
    assign out_row    = head.row;
    assign out_col    = head.col;
    assign frame_done = head.frame_done;

endmodule

>>> rtl/bbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_checker
// Port-level checks of the boundary extractor, bound to the top level.
// ----------------------------------------------------------------------------
module bbe_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic                            edge_set,
    input  logic [bbe_pkg::OUT_COORD_W-1:0] out_row,
    input  logic [bbe_pkg::OUT_COORD_W-1:0] out_col,
    input  logic                            frame_done
);

    // a held result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(edge_set) && $stable(out_row)
                                   && $stable(out_col) && $stable(frame_done))
        else $error("result changed while stalled");

    // the frame-end pixel is never on the first row or column
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done |-> (out_row != '0) && (out_col != '0))
        else $error("frame_done on a first row or column pixel");

    // two frame ends never follow each other
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && frame_done |=> !(res_valid && frame_done))
        else $error("back-to-back frame_done");

endmodule

bind binary_boundary_extract_top bbe_checker u_bbe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .edge_set   (edge_set),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_done (frame_done)
);
